/* sv/mpt_pkg.sv */
package mpt_pkg;

  // widths fixed by the field definitions
  localparam int LEN_W      = 10;
  localparam int CNT_W      = 10;
  localparam int ENTRY_W    = CNT_W + 1;
  localparam int REACH_BIT  = CNT_W;
  localparam int NUM_PIECES = 3;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_LENGTH_DEF = 1023;

  localparam logic [LEN_W-1:0] PIECE_FIRST_RST  = LEN_W'(10);
  localparam logic [LEN_W-1:0] PIECE_SECOND_RST = LEN_W'(11);
  localparam logic [LEN_W-1:0] PIECE_THIRD_RST  = LEN_W'(3);

  typedef logic [ENTRY_W-1:0] entry_t;

  // reachable with zero pieces, the entry for length zero
  localparam entry_t REACH_ENTRY = entry_t'(1) << REACH_BIT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIECE_FIRST  = 2'd0,
    CFG_PIECE_SECOND = 2'd1,
    CFG_PIECE_THIRD  = 2'd2
  } cfg_idx_e;

  // one table candidate: in range and the entry read for it
  typedef struct packed {
    logic   ok;
    entry_t entry;
  } cand_t;

endpackage

/* sv/mpt_table.sv */
module mpt_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  mpt_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_a_i,
  input  logic [AW-1:0]   raddr_b_i,
  output mpt_pkg::entry_t rdata_a_o,
  output mpt_pkg::entry_t rdata_b_o
);
  import mpt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_a_q;
  entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write, registered read
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* sv/mpt_best.sv */
module mpt_best (
  input  mpt_pkg::cand_t [mpt_pkg::NUM_PIECES-1:0] cand_i,
  output logic                                     found_o,
  output logic [mpt_pkg::CNT_W-1:0]                best_o
);
  import mpt_pkg::*;

  logic [CNT_W-1:0] cnt;

  // running max over the reachable candidates
  always_comb begin
    found_o = 1'b0;
    best_o  = '0;
    cnt     = '0;
    for (int k = 0; k < NUM_PIECES; k++) begin
      cnt = cand_i[k].entry[CNT_W-1:0];
      if (cand_i[k].ok && cand_i[k].entry[REACH_BIT]) begin
        if (!found_o || (cnt > best_o)) begin
          best_o  = cnt;
          found_o = 1'b1;
        end
      end
    end
  end

endmodule

/* sv/max_pieces_three_lengths_dp.sv */
// max pieces rod cutting with three configurable piece lengths
//
// request channel: present rod_length_i with start high; the request is taken
// at a rising edge where start is high and busy is low. busy stays high while
// the table is being rebuilt.
// result channel: done_o is high for exactly one cycle with cut_possible_o and
// max_pieces_o valid; the receiver cannot stall, so the result is gone after
// that cycle. max_pieces_o is 0 whenever cut_possible_o is 0.
// config channel: cfg_valid_i/cfg_ready_o write cfg_data_i to the piece length
// selected by cfg_index_i (0 first, 1 second, 2 third, others ignored);
// cfg_ready_o is always high. write only while the block is idle.
// rebuild: each entry passes the issue stage, then the update stage; the result
// is registered after the last write, or at once for a rod over MAX_LENGTH.
// the table is rebuilt one entry per cycle from length 0 up, set by the single
// write port per copy; the three candidate reads run in parallel on two
// dual-read copies; the next request can be taken in the cycle done_o is high.
// reset: piece lengths return to 10, 11 and 3; the table contents are not
// cleared, every entry read in a request is written earlier in that request.
module max_pieces_three_lengths_dp #(
  parameter int MAX_LENGTH = mpt_pkg::MAX_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [mpt_pkg::LEN_W-1:0]     rod_length_i,
  // result
  output logic                          done_o,
  output logic                          cut_possible_o,
  output logic [mpt_pkg::CNT_W-1:0]     max_pieces_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mpt_pkg::LEN_W-1:0]     cfg_data_i
);
  import mpt_pkg::*;

  localparam int DEPTH = MAX_LENGTH + 1;
  localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  // compare width wide enough for both table index and piece length
  localparam int CW    = (AW > LEN_W) ? AW : LEN_W;

  // piece length registers
  logic [LEN_W-1:0] piece_q [NUM_PIECES];

  // request and issue stage
  logic             busy_q;
  logic [LEN_W-1:0] len_q;
  logic             iss_act_q;
  logic [AW-1:0]    iss_n_q;
  logic [CW-1:0]    n_ext;
  logic [CW-1:0]    len_ext;
  logic             iss_last;
  logic [AW-1:0]    rd_addr [NUM_PIECES];
  logic [NUM_PIECES-1:0] ok_d;
  logic [NUM_PIECES-1:0] fwd_d;

  // update stage (table data returns here)
  logic                  s2_vld_q;
  logic                  s2_last_q;
  logic [AW-1:0]         s2_n_q;
  logic [NUM_PIECES-1:0] cand_ok_q;
  logic [NUM_PIECES-1:0] fwd_q;
  entry_t                fwd_data_q;
  entry_t                rdata [NUM_PIECES];
  entry_t                rdata_c_dup;
  cand_t [NUM_PIECES-1:0] cand;
  logic                  found;
  logic [CNT_W-1:0]      best_cnt;
  entry_t                wr_data;

  // result register
  logic             done_q;
  logic             cut_q;
  logic [CNT_W-1:0] pieces_q;

  logic req_acc;
  logic too_long;

  assign req_acc     = start && !busy_q;
  assign too_long    = 32'(rod_length_i) > MAX_LENGTH;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_q[0] <= PIECE_FIRST_RST;
      piece_q[1] <= PIECE_SECOND_RST;
      piece_q[2] <= PIECE_THIRD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PIECE_FIRST:  piece_q[0] <= cfg_data_i;
        CFG_PIECE_SECOND: piece_q[1] <= cfg_data_i;
        CFG_PIECE_THIRD:  piece_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // issue side: candidate addresses n - piece, checked for range
  assign n_ext    = CW'(iss_n_q);
  assign len_ext  = CW'(len_q);
  assign iss_last = (n_ext == len_ext);

  always_comb begin
    for (int k = 0; k < NUM_PIECES; k++) begin
      ok_d[k]    = (piece_q[k] != '0) && (CW'(piece_q[k]) <= n_ext);
      rd_addr[k] = AW'(n_ext - CW'(piece_q[k]));
      // entry being written this cycle is not yet in the array
      fwd_d[k]   = s2_vld_q && (rd_addr[k] == s2_n_q);
    end
  end

  // two copies of the table, written together, three read ports in total
  mpt_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table_ab (
    .clk_i     (clk_i),
    .we_i      (s2_vld_q),
    .waddr_i   (s2_n_q),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr[0]),
    .raddr_b_i (rd_addr[1]),
    .rdata_a_o (rdata[0]),
    .rdata_b_o (rdata[1])
  );

  mpt_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table_c (
    .clk_i     (clk_i),
    .we_i      (s2_vld_q),
    .waddr_i   (s2_n_q),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr[2]),
    .raddr_b_i (rd_addr[2]),
    .rdata_a_o (rdata[2]),
    .rdata_b_o (rdata_c_dup)
  );

  // update side: pick forwarded or stored entry, best of three, plus one
  always_comb begin
    for (int k = 0; k < NUM_PIECES; k++) begin
      cand[k].ok    = cand_ok_q[k];
      cand[k].entry = fwd_q[k] ? fwd_data_q : rdata[k];
    end
  end

  mpt_best u_best (
    .cand_i  (cand),
    .found_o (found),
    .best_o  (best_cnt)
  );

  always_comb begin
    if (s2_n_q == '0) begin
      wr_data = REACH_ENTRY;
    end else if (found) begin
      wr_data = {1'b1, CNT_W'(best_cnt + 1'b1)};
    end else begin
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      iss_act_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      // strobe on the last table write, or at once for a rod past the table
      done_q   <= (s2_vld_q && s2_last_q) || (req_acc && too_long);
      s2_vld_q <= iss_act_q;
      if (iss_act_q && iss_last) begin
        iss_act_q <= 1'b0;
      end
      if (s2_vld_q && s2_last_q) begin
        busy_q <= 1'b0;
      end
      if (req_acc && !too_long) begin
        busy_q    <= 1'b1;
        iss_act_q <= 1'b1;
      end
    end
  end

  // payload and pipeline data, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      len_q   <= rod_length_i;
      iss_n_q <= '0;
    end else if (iss_act_q) begin
      iss_n_q <= iss_n_q + 1'b1;
    end
    s2_n_q     <= iss_n_q;
    s2_last_q  <= iss_last;
    cand_ok_q  <= ok_d;
    fwd_q      <= fwd_d;
    fwd_data_q <= wr_data;
    if (req_acc && too_long) begin
      cut_q    <= 1'b0;
      pieces_q <= '0;
    end else if (s2_vld_q && s2_last_q) begin
      cut_q    <= wr_data[REACH_BIT];
      pieces_q <= wr_data[REACH_BIT] ? wr_data[CNT_W-1:0] : '0;
    end
  end

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign cut_possible_o = cut_q;
  assign max_pieces_o   = pieces_q;

`ifndef SYNTHESIS
  // a result never shows while a rebuild is still running
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // every accepted request either starts a rebuild or answers at once
  a_req_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("request accepted without progress");

  // table writes never run past the requested length
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (CW'(s2_n_q) <= CW'(len_q)))
    else $error("table write beyond rod length");

  // no piece count reported for an impossible cut
  a_zero_when_impossible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !cut_possible_o) |-> (max_pieces_o == '0))
    else $error("nonzero count for impossible cut");

  // both read ports of the third copy look at the same entry
  a_copy_ports_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (rdata_c_dup === rdata[2]))
    else $error("third table copy read ports disagree");
`endif

endmodule

/* bench/max_pieces_three_lengths_dp_test.sv */
module max_pieces_three_lengths_dp_test;
  import mpt_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int MAX_LEN         = MAX_LENGTH_DEF;
  localparam int WATCHDOG_LIMIT  = 10000;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int NUM_DIRECTED    = 24;

  // index beyond the three piece lengths, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // one answer of the block
  typedef struct packed {
    logic             cut_possible;
    logic [CNT_W-1:0] max_pieces;
  } cut_t;

  // one row of the directed table, want only valid when has_want is set
  typedef struct packed {
    logic [LEN_W-1:0] rod_length;
    logic             has_want;
    cut_t             want;
  } rod_row_t;

  // answer still owed by the block, with its rod for the report
  typedef struct packed {
    logic [LEN_W-1:0] rod_length;
    cut_t             cut;
  } pending_cut_t;

  // directed requests under the reset piece lengths 10, 11 and 3
  localparam rod_row_t DIRECTED_RODS [NUM_DIRECTED] = '{
    '{0,    1, '{1, 0}},   // zero length rod, zero pieces
    '{1,    1, '{0, 0}},   // shorter than every piece
    '{2,    1, '{0, 0}},
    '{3,    1, '{1, 1}},   // one short piece
    '{4,    1, '{0, 0}},   // unreachable, count forced to zero
    '{5,    1, '{0, 0}},
    '{6,    1, '{1, 2}},
    '{7,    1, '{0, 0}},
    '{9,    1, '{1, 3}},
    '{10,   1, '{1, 1}},   // exactly the first piece
    '{11,   1, '{1, 1}},   // exactly the second piece
    '{1023, 1, '{1, 341}}, // longest rod, all short pieces
    '{13,   0, '{0, 0}},
    '{14,   0, '{0, 0}},
    '{20,   0, '{0, 0}},
    '{22,   0, '{0, 0}},
    '{23,   0, '{0, 0}},
    '{100,  0, '{0, 0}},
    '{255,  0, '{0, 0}},
    '{256,  0, '{0, 0}},
    '{341,  0, '{0, 0}},
    '{512,  0, '{0, 0}},
    '{700,  0, '{0, 0}},
    '{1022, 0, '{0, 0}}
  };

  logic             clk_i;
  logic             rst_ni       = 1'b0;
  logic             start        = 1'b0;
  logic             busy;
  logic [LEN_W-1:0] rod_length_i = '0;
  logic             done_o;
  logic             cut_possible_o;
  logic [CNT_W-1:0] max_pieces_o;
  logic             cfg_valid_i  = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_PIECE_FIRST;
  logic [LEN_W-1:0] cfg_data_i   = '0;

  // predictor state: own copy of the piece lengths and the count table
  logic [LEN_W-1:0] piece_len_q [NUM_PIECES];
  entry_t           best_tbl [0:MAX_LEN];

  pending_cut_t     expected_cuts [$];
  int unsigned      fail_count   = 0;
  int unsigned      quiet_cycles = 0;
  bit               idle_en      = 1'b1;
  int               gap_span     = 6;

  max_pieces_three_lengths_dp #(
    .MAX_LENGTH(MAX_LEN)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .rod_length_i  (rod_length_i),
    .done_o        (done_o),
    .cut_possible_o(cut_possible_o),
    .max_pieces_o  (max_pieces_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // bottom-up table fill for one rod, same walk as the hardware
  function automatic cut_t predict_cut(input logic [LEN_W-1:0] rod);
    cut_t             res;
    logic             found;
    logic [CNT_W-1:0] best;
    entry_t           cand;
    res = '0;
    // rod past the table: nothing is touched
    if (int'(rod) > MAX_LEN) return res;
    best_tbl[0] = REACH_ENTRY;
    for (int n = 1; n <= int'(rod); n++) begin
      found = 1'b0;
      best  = '0;
      for (int p = 0; p < NUM_PIECES; p++) begin
        // a zero piece length never counts, nor one that overshoots
        if (piece_len_q[p] != '0 && int'(piece_len_q[p]) <= n) begin
          cand = best_tbl[n - int'(piece_len_q[p])];
          if (cand[REACH_BIT] && (!found || cand[CNT_W-1:0] > best)) begin
            best  = cand[CNT_W-1:0];
            found = 1'b1;
          end
        end
      end
      best_tbl[n] = found ? (REACH_ENTRY | entry_t'(best + 1'b1)) : '0;
    end
    cand = best_tbl[rod];
    if (cand[REACH_BIT]) begin
      res.cut_possible = 1'b1;
      res.max_pieces   = cand[CNT_W-1:0];
    end
    return res;
  endfunction

  // mostly short rods, a few long ones so the upper length bits toggle
  function automatic logic [LEN_W-1:0] pick_rod_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return LEN_W'($urandom_range(0, 63));
    if (sel < 90) return LEN_W'($urandom_range(64, 255));
    return LEN_W'($urandom_range(256, MAX_LEN));
  endfunction

  // small piece lengths keep most rods reachable, zero and large ones too
  function automatic logic [LEN_W-1:0] pick_piece_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return LEN_W'($urandom_range(100, MAX_LEN));
    return LEN_W'($urandom_range(1, 15));
  endfunction

  // one request; start is left high so the next request can follow at once
  task automatic send_rod(input logic [LEN_W-1:0] rod, input logic has_want,
                          input cut_t want);
    cut_t predicted;
    // random hold-off, its length spread over the previous rebuild
    if (idle_en && $urandom_range(99) < 18) begin
      start        <= 1'b0;
      rod_length_i <= LEN_W'($urandom);
      repeat ($urandom_range(1, gap_span)) @(posedge clk_i);
    end
    start        <= 1'b1;
    rod_length_i <= rod;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // request taken at this edge
    predicted = predict_cut(rod);
    expected_cuts.push_back('{rod, has_want ? want : predicted});
    gap_span = int'(rod) + 6;
  endtask

  // one register write; valid stays high for a following write
  task automatic write_piece(input logic [CFG_IDX_W-1:0] idx,
                             input logic [LEN_W-1:0] len);
    if (idle_en && $urandom_range(99) < 18) begin
      cfg_valid_i <= 1'b0;
      cfg_data_i  <= LEN_W'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PIECE_FIRST:  piece_len_q[0] = len;
      CFG_PIECE_SECOND: piece_len_q[1] = len;
      CFG_PIECE_THIRD:  piece_len_q[2] = len;
      default: ;
    endcase
  endtask

  task automatic set_pieces(input logic [LEN_W-1:0] first_len,
                            input logic [LEN_W-1:0] second_len,
                            input logic [LEN_W-1:0] third_len);
    write_piece(CFG_PIECE_FIRST, first_len);
    write_piece(CFG_PIECE_SECOND, second_len);
    write_piece(CFG_PIECE_THIRD, third_len);
    // unmapped index, must leave all three lengths alone
    write_piece(CFG_UNUSED, LEN_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // drop start and let every owed answer come back
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_cuts.size() != 0 || busy) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // answer check, one strobe per request, no back-pressure possible
  always @(posedge clk_i) begin
    pending_cut_t head;
    if (rst_ni && done_o) begin
      if (expected_cuts.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected answer: cut_possible=%0b max_pieces=%0d",
                   cut_possible_o, max_pieces_o);
        fail_count++;
      end else begin
        head = expected_cuts.pop_front();
        if (cut_possible_o !== head.cut.cut_possible ||
            max_pieces_o !== head.cut.max_pieces) begin
          if (fail_count < MAX_REPORTS)
            $display("rod %0d: expected cut_possible=%0b max_pieces=%0d, got %0b %0d",
                     head.rod_length, head.cut.cut_possible, head.cut.max_pieces,
                     cut_possible_o, max_pieces_o);
          fail_count++;
        end
      end
    end
  end

  // cycles with no request, no answer and no register write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    // predictor starts from the reset piece lengths
    piece_len_q[0] = PIECE_FIRST_RST;
    piece_len_q[1] = PIECE_SECOND_RST;
    piece_len_q[2] = PIECE_THIRD_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, reset piece lengths
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_rod(DIRECTED_RODS[i].rod_length, DIRECTED_RODS[i].has_want,
               DIRECTED_RODS[i].want);
    wait_idle();

    // random phases, each under its own piece lengths
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      // three phases back to back with no hold-offs at all
      idle_en = !(ph >= 7 && ph <= 9);
      case (ph)
        1: set_pieces(1, 1, 1);            // every rod reachable, count equals length
        2: set_pieces(1023, 1023, 1023);   // only the empty and the longest rod
        3: set_pieces(0, 0, 0);            // no usable piece at all
        4: set_pieces(2, 0, 5);
        5: set_pieces(7, 4, 1023);
        6: set_pieces(PIECE_FIRST_RST, PIECE_SECOND_RST, PIECE_THIRD_RST);
        default: set_pieces(pick_piece_len(), pick_piece_len(), pick_piece_len());
      endcase
      // full table rebuild once per setting
      send_rod(LEN_W'(MAX_LEN), 1'b0, '0);
      for (int k = 1; k < ITEMS_PER_PHASE; k++)
        send_rod(pick_rod_length(), 1'b0, '0);
      wait_idle();
    end

    // room for a stray answer after the last rebuild
    repeat (MAX_LEN + 8) @(posedge clk_i);
    if (fail_count == 0 && expected_cuts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
